/* hw/rtl/neighbor_solicit_frame_builder_macros.svh */
// assertion macros used by the checker file
`ifndef NEIGHBOR_SOLICIT_FRAME_BUILDER_MACROS_SVH
`define NEIGHBOR_SOLICIT_FRAME_BUILDER_MACROS_SVH

// same-cycle implication, off during reset
`define NSFB_ASSERT_IMPL(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("nsfb checker: same-cycle property failed");

// next-cycle implication, off during reset
`define NSFB_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("nsfb checker: next-cycle property failed");

`endif

/* hw/rtl/nsfb_pkg.sv */
package nsfb_pkg;

  // frame layout
  localparam int FrameWords = 43;
  localparam int WordIdxW = $clog2(FrameWords);
  localparam logic [WordIdxW-1:0] LastWordIdx = WordIdxW'(FrameWords - 1);
  localparam logic [WordIdxW-1:0] EthTypeIdx = WordIdxW'(6);
  localparam logic [WordIdxW-1:0] NsTypeIdx = WordIdxW'(27);
  localparam logic [15:0] EthTypeWord = 16'h86dd;
  localparam logic [15:0] NsTypeWord = 16'h8700;

  // checksum walk: 27 variable words plus one folded constant word
  localparam int SumWords = 28;
  localparam int SumLanes = 4;
  localparam int SumSteps = SumWords / SumLanes;
  localparam int SumStepW = $clog2(SumSteps);
  localparam int SumVecW = SumWords * 16;
  localparam int SumShift = SumLanes * 16;
  localparam int LaneSumW = 16 + $clog2(SumLanes);
  localparam int AccW = 16 + $clog2(SumWords);
  // upper-layer length 32 + next header 58 + type 135 word + option type/length word
  localparam logic [15:0] CksumConst = 16'h885b;

  // queue between front and back
  localparam int QueueDepth = 2;

  // configuration register indexes
  localparam int RegIdxW = 3;
  typedef enum logic [RegIdxW-1:0] {
    REG_SOURCE_MAC       = 3'd0,
    REG_SOURCE_IP_HIGH   = 3'd1,
    REG_SOURCE_IP_LOW    = 3'd2,
    REG_UNICAST_DEST_MAC = 3'd3,
    REG_MULTICAST_MODE   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [63:0] source_ip_high;
    logic [63:0] source_ip_low;
    logic [47:0] unicast_dest_mac;
    logic        multicast_mode;
  } cfg_t;

  typedef struct packed {
    logic [63:0] target_high;
    logic [63:0] target_low;
    logic [15:0] checksum;
  } q_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SUM,
    F_PUSH
  } front_state_t;

  // ipv6 destination: solicited-node group or the target itself
  function automatic logic [127:0] dest_ip(input logic mcast, input logic [63:0] th,
                                           input logic [63:0] tl);
    logic [127:0] ip;
    if (mcast) begin
      ip = {64'hff02000000000000, 40'h00000001ff, tl[23:0]};
    end else begin
      ip = {th, tl};
    end
    return ip;
  endfunction

endpackage

/* hw/rtl/neighbor_solicit_frame_builder.sv */
// throughput: frames of 43 words, one word per cycle while the receiver pops,
//   set by the word sequencer of the back end; the front end handles each
//   request as a load, seven four-word checksum steps and the queue write
// a new request is taken while the previous frame still streams out
// reset (rst, synchronous): queue and holding slot empty, registers 0, multicast_mode 1
module neighbor_solicit_frame_builder
  import nsfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [63:0]        target_high,
  input  logic [63:0]        target_low,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        frame_word,
  output logic               last_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  cfg_t     cfg;
  logic     fq_push;
  logic     fq_pop;
  logic     fq_full;
  logic     fq_empty;
  q_entry_t fq_wr_data;
  q_entry_t fq_rd_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_mac       <= '0;
      cfg.source_ip_high   <= '0;
      cfg.source_ip_low    <= '0;
      cfg.unicast_dest_mac <= '0;
      cfg.multicast_mode   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_SOURCE_MAC:       cfg.source_mac       <= cfg_data[47:0];
        REG_SOURCE_IP_HIGH:   cfg.source_ip_high   <= cfg_data;
        REG_SOURCE_IP_LOW:    cfg.source_ip_low    <= cfg_data;
        REG_UNICAST_DEST_MAC: cfg.unicast_dest_mac <= cfg_data[47:0];
        REG_MULTICAST_MODE:   cfg.multicast_mode   <= cfg_data[0];
        default:              cfg.multicast_mode   <= cfg.multicast_mode;
      endcase
    end
  end

  // request intake and checksum
  nsfb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .target_high (target_high),
    .target_low  (target_low),
    .q_push      (fq_push),
    .q_entry     (fq_wr_data),
    .q_full      (fq_full)
  );

  // decoupling queue
  nsfb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_wr_data),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .rd_data (fq_rd_data),
    .empty   (fq_empty)
  );

  // frame word streaming
  nsfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (fq_empty),
    .q_pop      (fq_pop),
    .q_entry    (fq_rd_data),
    .empty      (empty),
    .pop        (pop),
    .frame_word (frame_word),
    .last_word  (last_word)
  );

endmodule

/* hw/rtl/nsfb_queue.sv */
module nsfb_queue
  import nsfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  q_entry_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output q_entry_t rd_data,
  output logic     empty
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  q_entry_t        mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntFull);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* hw/rtl/nsfb_front.sv */
module nsfb_front
  import nsfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        push,
  output logic        full,
  input  logic [63:0] target_high,
  input  logic [63:0] target_low,
  output logic        q_push,
  output q_entry_t    q_entry,
  input  logic        q_full
);

  localparam logic [SumStepW-1:0] StepLast = SumStepW'(SumSteps - 1);

  front_state_t        state;
  front_state_t        state_next;
  logic                hold_valid;
  logic [63:0]         hold_th;
  logic [63:0]         hold_tl;
  logic [63:0]         tgt_th;
  logic [63:0]         tgt_tl;
  logic [SumVecW-1:0]  sum_vec;
  logic [AccW-1:0]     acc;
  logic [AccW-1:0]     acc_next;
  logic [SumStepW-1:0] step_cnt;
  logic [LaneSumW-1:0] lane_sum;
  logic [16:0]         fold1;
  logic [15:0]         fold2;
  logic                load;
  logic                step_en;
  logic                accept;

  assign full   = hold_valid && !load;
  assign accept = push && !full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (hold_valid) state_next = F_SUM;
      end
      F_SUM: begin
        if (step_cnt == StepLast) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load    = 1'b0;
    step_en = 1'b0;
    q_push  = 1'b0;
    case (state)
      F_IDLE:  load = hold_valid;
      F_SUM:   step_en = 1'b1;
      F_PUSH:  q_push = !q_full;
      default: load = 1'b0;
    endcase
  end

  // four-word slice of the checksum walk
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < SumLanes; i++) begin
      lane_sum = lane_sum + LaneSumW'(sum_vec[SumVecW-1-16*i -: 16]);
    end
    acc_next = acc + AccW'(lane_sum);
  end

  // end-around carry fold and complement
  assign fold1 = {1'b0, acc[15:0]} + 17'(acc[AccW-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  assign q_entry.target_high = tgt_th;
  assign q_entry.target_low  = tgt_tl;
  assign q_entry.checksum    = ~fold2;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      hold_valid <= 1'b0;
      step_cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (load) begin
        hold_valid <= 1'b0;
      end
      if (load) begin
        step_cnt <= '0;
      end else if (step_en) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  // request holding slot and checksum datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_th <= target_high;
      hold_tl <= target_low;
    end
    if (load) begin
      tgt_th  <= hold_th;
      tgt_tl  <= hold_tl;
      acc     <= '0;
      sum_vec <= {cfg.source_ip_high, cfg.source_ip_low,
                  dest_ip(cfg.multicast_mode, hold_th, hold_tl),
                  hold_th, hold_tl, cfg.source_mac, CksumConst};
    end else if (step_en) begin
      acc     <= acc_next;
      sum_vec <= sum_vec << SumShift;
    end
  end

endmodule

/* hw/rtl/nsfb_back.sv */
module nsfb_back
  import nsfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  output logic        q_pop,
  input  q_entry_t    q_entry,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] frame_word,
  output logic        last_word
);

  typedef logic [FrameWords-1:0][15:0] frame_t;

  q_entry_t            cur;
  logic                active;
  logic [WordIdxW-1:0] widx;
  logic                out_valid;
  logic                advance;
  logic                finish;
  logic [47:0]         dest_mac;
  frame_t              frame;

  assign advance = active && (!out_valid || pop);
  assign finish  = advance && (widx == LastWordIdx);
  assign q_pop   = !q_empty && (!active || finish);
  assign empty   = !out_valid;

  // destination mac by mode
  assign dest_mac = cfg.multicast_mode ? {24'h3333ff, cur.target_low[23:0]}
                                       : cfg.unicast_dest_mac;

  // whole frame, first word in the top slot
  assign frame = {dest_mac, cfg.source_mac, EthTypeWord,
                  32'h60000000, 16'h0020, 8'd58, 8'd255,
                  cfg.source_ip_high, cfg.source_ip_low,
                  dest_ip(cfg.multicast_mode, cur.target_high, cur.target_low),
                  NsTypeWord, cur.checksum, 32'h0,
                  cur.target_high, cur.target_low,
                  8'd1, 8'd1, cfg.source_mac};

  // frame sequencing and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      widx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (finish) begin
        active <= 1'b0;
      end
      if (q_pop || finish) begin
        widx <= '0;
      end else if (advance) begin
        widx <= widx + 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // current entry and output word register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
    if (advance) begin
      frame_word <= frame[LastWordIdx - widx];
      last_word  <= (widx == LastWordIdx);
    end
  end

endmodule

/* hw/rtl/nsfb_checker.sv */
`include "neighbor_solicit_frame_builder_macros.svh"

module nsfb_checker
  import nsfb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [15:0] frame_word,
  input logic        last_word
);

  logic [WordIdxW-1:0] pos;

  // position of the shown word within its frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (pop && !empty) begin
      pos <= (pos == LastWordIdx) ? '0 : pos + 1'b1;
    end
  end

  // a stalled word stays put
  `NSFB_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable({frame_word, last_word}))

  // last marker only on the final word of each frame
  `NSFB_ASSERT_IMPL(a_last, clk, rst, !empty, last_word == (pos == LastWordIdx))

  // ethertype sits at its fixed word
  `NSFB_ASSERT_IMPL(a_ethtype, clk, rst, !empty && pos == EthTypeIdx, frame_word == EthTypeWord)

  // solicitation type and code at the start of the icmpv6 message
  `NSFB_ASSERT_IMPL(a_nstype, clk, rst, !empty && pos == NsTypeIdx, frame_word == NsTypeWord)

endmodule

bind neighbor_solicit_frame_builder nsfb_checker u_nsfb_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .frame_word (frame_word),
  .last_word  (last_word)
);

/* sim/neighbor_solicit_frame_builder_tb.sv */
`timescale 1ns / 100ps

module neighbor_solicit_frame_builder_tb;
  import nsfb_pkg::*;

  // run control
  localparam int RUN_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 80;
  localparam int REPORT_MAX = 10;

  // frame layout as seen by the predictor
  localparam int FRAME_BITS = 16 * FrameWords;
  localparam int IP_SRC_WORD = 11;
  localparam int CKSUM_WORD = 28;
  localparam logic [31:0] IPV6_VER_WORD = 32'h6000_0000;
  localparam logic [15:0] NS_PAYLOAD_LEN = 16'd32;
  localparam logic [7:0] NEXT_HDR_ICMPV6 = 8'd58;
  localparam logic [7:0] HOP_LIMIT_MAX = 8'd255;
  localparam logic [7:0] OPT_SRC_LLADDR = 8'd1;
  localparam logic [7:0] OPT_LEN_ONE = 8'd1;
  localparam logic [23:0] MCAST_MAC_PREFIX = 24'h3333ff;
  localparam logic [103:0] SOLICITED_PREFIX = {64'hff02_0000_0000_0000, 40'h00_0000_01ff};

  // register indexes past the end of the map
  localparam logic [RegIdxW-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [RegIdxW-1:0] REG_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } ns_word_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               full;
  logic [63:0]        target_high;
  logic [63:0]        target_low;
  logic               empty;
  logic               pop;
  logic [15:0]        frame_word;
  logic               last_word;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RegIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;

  // shadow copy of the register file
  logic [47:0] my_mac;
  logic [63:0] my_ip_high;
  logic [63:0] my_ip_low;
  logic [47:0] peer_mac;
  logic        mcast_on;

  ns_word_t frame_words_due[$];
  int fault_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_left = 0;

  neighbor_solicit_frame_builder uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .target_high(target_high),
    .target_low(target_low),
    .empty(empty),
    .pop(pop),
    .frame_word(frame_word),
    .last_word(last_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // expected 43 words of the solicitation frame for one target
  function automatic void build_solicit_frame(input logic [63:0] th, input logic [63:0] tl);
    logic [FRAME_BITS-1:0] frame;
    logic [47:0] dst_mac;
    logic [127:0] dst_ip;
    logic [31:0] acc;
    ns_word_t w;
    if (mcast_on) begin
      dst_mac = {MCAST_MAC_PREFIX, tl[23:0]};
      dst_ip = {SOLICITED_PREFIX, tl[23:0]};
    end else begin
      dst_mac = peer_mac;
      dst_ip = {th, tl};
    end
    // checksum and reserved bytes start out as zero
    frame = {dst_mac, my_mac, EthTypeWord, IPV6_VER_WORD, NS_PAYLOAD_LEN, NEXT_HDR_ICMPV6,
             HOP_LIMIT_MAX, my_ip_high, my_ip_low, dst_ip, NsTypeWord, 48'h0, th, tl,
             OPT_SRC_LLADDR, OPT_LEN_ONE, my_mac};
    // pseudo-header addresses and the icmp message are contiguous words
    acc = 32'(NS_PAYLOAD_LEN) + 32'(NEXT_HDR_ICMPV6);
    for (int k = IP_SRC_WORD; k < FrameWords; k++) begin
      acc = acc + 32'(frame[FRAME_BITS-1-16*k -: 16]);
    end
    while (acc[31:16] != 16'h0) begin
      acc = 32'(acc[15:0]) + 32'(acc[31:16]);
    end
    frame[FRAME_BITS-1-16*CKSUM_WORD -: 16] = ~acc[15:0];
    for (int k = 0; k < FrameWords; k++) begin
      w.word = frame[FRAME_BITS-1-16*k -: 16];
      w.last = (k == FrameWords - 1);
      frame_words_due.push_back(w);
    end
  endfunction

  // zero, all ones or random
  function automatic logic [63:0] pick_value();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one register write; called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_MAC:       my_mac = data[47:0];
      REG_SOURCE_IP_HIGH:   my_ip_high = data;
      REG_SOURCE_IP_LOW:    my_ip_low = data;
      REG_UNICAST_DEST_MAC: peer_mac = data[47:0];
      REG_MULTICAST_MODE:   mcast_on = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // offer one target; push stays high for a back-to-back request
  task automatic send_target(input logic [63:0] th, input logic [63:0] tl);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2 * FrameWords)) @(negedge clk);
    end
    push <= 1'b1;
    target_high <= th;
    target_low <= tl;
    do @(posedge clk); while (full);
    build_solicit_frame(th, tl);
    @(negedge clk);
  endtask

  // stop sending and let every frame drain
  task automatic wait_frames_done();
    push <= 1'b0;
    while (frame_words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic rand_config();
    write_reg(REG_SOURCE_MAC, pick_value());
    write_reg(REG_SOURCE_IP_HIGH, pick_value());
    write_reg(REG_SOURCE_IP_LOW, pick_value());
    write_reg(REG_UNICAST_DEST_MAC, pick_value());
    write_reg(REG_MULTICAST_MODE, pick_value());
    if ($urandom_range(1) == 1) begin
      write_reg(RegIdxW'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), pick_value());
    end
  endtask

  // reset values: multicast, all addresses zero
  task automatic test_reset_state();
    send_target('0, '0);
    send_target('1, '1);
    wait_frames_done();
  endtask

  // oversized data, mode taken from bit 0, spare indexes ignored
  task automatic test_register_writes();
    write_reg(REG_SOURCE_MAC, '1);
    write_reg(REG_SOURCE_IP_HIGH, '1);
    write_reg(REG_SOURCE_IP_LOW, '1);
    write_reg(REG_UNICAST_DEST_MAC, '1);
    write_reg(REG_MULTICAST_MODE, 64'hffff_ffff_ffff_fffe);
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
      write_reg(RegIdxW'(i), {$urandom, $urandom});
    end
    send_target('1, '1);
    send_target('0, '0);
    send_target({16{4'h5}}, {16{4'ha}});
    send_target({16{4'ha}}, {16{4'h5}});
    wait_frames_done();
  endtask

  // solicited-node addressing across the low target bytes
  task automatic test_address_extremes();
    write_reg(REG_MULTICAST_MODE, '1);
    send_target('0, 64'h0000_0000_00ff_ffff);
    send_target('1, 64'hffff_ffff_ff00_0000);
    send_target({$urandom, $urandom}, {$urandom, $urandom});
    wait_frames_done();
    // unicast with an all-zero register file
    write_reg(REG_SOURCE_MAC, '0);
    write_reg(REG_SOURCE_IP_HIGH, '0);
    write_reg(REG_SOURCE_IP_LOW, '0);
    write_reg(REG_UNICAST_DEST_MAC, '0);
    write_reg(REG_MULTICAST_MODE, '0);
    send_target('1, '1);
    send_target('0, '0);
    send_target({16{4'h5}}, {16{4'h5}});
    wait_frames_done();
  endtask

  // random targets under each idling mix
  task automatic test_random_phases();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      rand_config();
      repeat (PHASE_ITEMS) send_target(pick_value(), pick_value());
      wait_frames_done();
    end
  endtask

  // long output hold so the block fills and stalls its input
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold_left = HOLD_CYCLES;
    repeat (8) send_target(pick_value(), pick_value());
    wait_frames_done();
  endtask

  // sender pauses until every frame is out, then resumes
  task automatic test_drain_pause();
    send_idle_pct = 28;
    recv_stall_pct = 28;
    rand_config();
    repeat (6) send_target(pick_value(), pick_value());
    wait_frames_done();
    repeat (6) send_target(pick_value(), pick_value());
    wait_frames_done();
  endtask

  // receiver: random stalls plus an optional long hold
  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      pop <= 1'b0;
      recv_hold_left = recv_hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each popped word with the oldest expected one
  always @(posedge clk) begin : check_words
    ns_word_t want;
    if (!rst && pop && !empty) begin
      if (frame_words_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
          $display("unexpected frame word %h last %b", frame_word, last_word);
        end
      end else begin
        want = frame_words_due.pop_front();
        if (frame_word !== want.word || last_word !== want.last) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("mismatch: expected word %h last %b, got word %h last %b",
                     want.word, want.last, frame_word, last_word);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    target_high = '0;
    target_low = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SOURCE_MAC;
    cfg_data = '0;
    my_mac = '0;
    my_ip_high = '0;
    my_ip_low = '0;
    peer_mac = '0;
    mcast_on = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_writes();
    test_address_extremes();
    test_random_phases();
    test_output_hold();
    test_drain_pause();

    if (fault_count == 0 && frame_words_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nsfb_pkg.sv
hw/rtl/nsfb_queue.sv
hw/rtl/nsfb_front.sv
hw/rtl/nsfb_back.sv
hw/rtl/neighbor_solicit_frame_builder.sv
hw/rtl/nsfb_checker.sv
sim/neighbor_solicit_frame_builder_tb.sv
